### rtl/ufg_pkg.sv
// Shared types and constants for the grid union-find cut checker.
// Holds the sequencer state type, opcode and register codes, and direction tables.
// No dependencies; ufg_seq and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package ufg_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_JPREP,
        ST_CNODE,
        ST_RD,
        ST_EVAL,
        ST_JW1,
        ST_JW2,
        ST_CEVAL,
        ST_EMIT
    } ufg_state_t;

    localparam logic OP_JOIN  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Register index, taken from paddr bit 2.
    localparam logic REG_HEIGHT = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    typedef logic signed [1:0] ofs_t;

    // Orthogonal directions in the order up, right, down, left.
    localparam ofs_t DIR_DR [4] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};
    localparam ofs_t DIR_DC [4] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};

    typedef struct packed {
        logic merged;
        logic check_ok;
    } ufg_res_t;

    // Direction before d, i.e. (d + 3) mod 4.
    function automatic logic [1:0] prev_dir(input logic [1:0] d);
        return d + 2'd3;
    endfunction

    // Direction after d, i.e. (d + 1) mod 4.
    function automatic logic [1:0] next_dir(input logic [1:0] d);
        return d + 2'd1;
    endfunction

endpackage

`default_nettype wire

### rtl/ufg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the forest table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ufg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1025,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/ufg_seq.sv
// Sequencer of the union-find checker: clearing pass, root walks, link writes
// and the diagonal test, all around one forest RAM port pair.
// Depends on ufg_pkg and ufg_ram.
`timescale 1ns / 1ps
`default_nettype none

module ufg_seq #(
    parameter int MAX_SIDE = 32,
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE + 1,
    localparam int NODE_W = $clog2(DEPTH),
    localparam int SIDE_W = $clog2(MAX_SIDE),
    localparam int CFG_W  = $clog2(MAX_SIDE + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_op,
    input  wire logic [NODE_W-1:0] in_cell_a,
    input  wire logic [NODE_W-1:0] in_cell_b,
    input  wire logic [SIDE_W-1:0] in_row,
    input  wire logic [SIDE_W-1:0] in_col,
    input  wire logic [CFG_W-1:0]  h_eff,
    input  wire logic [CFG_W-1:0]  w_eff,
    input  wire logic              out_free,
    output logic                   res_valid,
    output ufg_pkg::ufg_res_t      res
);
    import ufg_pkg::*;

    localparam int SW = SIDE_W + 2;
    localparam int PW = SIDE_W + CFG_W;
    localparam logic [NODE_W-1:0] BORDER = NODE_W'(MAX_SIDE * MAX_SIDE);

    ufg_state_t        state_reg, state_next;
    logic [NODE_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]        k_reg, k_next;
    logic              op_reg, op_next;
    logic [NODE_W-1:0] a_reg, a_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic [SIDE_W-1:0] row_reg, row_next;
    logic [SIDE_W-1:0] col_reg, col_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] ids_reg [4];
    logic [NODE_W-1:0] ids_next [4];
    logic [NODE_W-1:0] size_reg, size_next;
    logic [NODE_W-1:0] sum_reg, sum_next;
    ufg_res_t          res_reg, res_next;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic [NODE_W:0]   mem_wdata;
    logic [NODE_W-1:0] mem_raddr;
    logic [NODE_W:0]   mem_rdata;
    logic              rd_root;
    logic [NODE_W-1:0] rd_val;

    logic [NODE_W-1:0] diag_node;
    logic              cut_ok;
    logic              a_bad;
    logic              b_bad;

    function automatic logic in_grid(input logic signed [SW-1:0] r,
                                     input logic signed [SW-1:0] c,
                                     input logic [CFG_W-1:0] h,
                                     input logic [CFG_W-1:0] w);
        logic signed [SW-1:0] hs;
        logic signed [SW-1:0] ws;
        hs = signed'(SW'(h));
        ws = signed'(SW'(w));
        return (r >= 0) && (c >= 0) && (r < hs) && (c < ws);
    endfunction

    ufg_ram #(
        .WIDTH(NODE_W + 1),
        .DEPTH(DEPTH)
    ) u_forest (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Entry layout: root flag on top, below it the size of a root or the parent.
    assign rd_root = mem_rdata[NODE_W];
    assign rd_val  = mem_rdata[NODE_W-1:0];

    // Node index of diagonal k_reg of the checked cell, border when off grid.
    always_comb begin
        logic signed [SW-1:0] rs;
        logic signed [SW-1:0] cs;
        logic signed [SW-1:0] r2;
        logic signed [SW-1:0] c2;
        logic [1:0]           dj;
        logic [PW-1:0]        prod;
        rs   = signed'(SW'(row_reg));
        cs   = signed'(SW'(col_reg));
        dj   = prev_dir(k_reg);
        r2   = rs + SW'(DIR_DR[k_reg]) + SW'(DIR_DR[dj]);
        c2   = cs + SW'(DIR_DC[k_reg]) + SW'(DIR_DC[dj]);
        prod = PW'(r2[SIDE_W-1:0]) * PW'(w_eff);
        if (in_grid(r2, c2, h_eff, w_eff)) begin
            diag_node = NODE_W'(prod + PW'(c2[SIDE_W-1:0]));
        end else begin
            diag_node = BORDER;
        end
    end

    // Diagonal roots are compared pairwise once all four are known.
    always_comb begin
        logic signed [SW-1:0] rs;
        logic signed [SW-1:0] cs;
        logic signed [SW-1:0] ro;
        logic signed [SW-1:0] co;
        logic signed [SW-1:0] hs;
        logic signed [SW-1:0] ws;
        rs = signed'(SW'(row_reg));
        cs = signed'(SW'(col_reg));
        hs = signed'(SW'(h_eff));
        ws = signed'(SW'(w_eff));
        cut_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            ro = rs + SW'(DIR_DR[i]);
            co = cs + SW'(DIR_DC[i]);
            if (in_grid(ro, co, h_eff, w_eff) &&
                ids_reg[i] == ids_reg[next_dir(2'(i))]) begin
                cut_ok = 1'b0;
            end
        end
        if (rs > 0 && rs + 1 < hs && cs > 0 && cs + 1 < ws) begin
            if (ids_reg[0] == ids_reg[2] || ids_reg[1] == ids_reg[3]) begin
                cut_ok = 1'b0;
            end
        end
    end

    // A join node is rejected when it is neither a grid cell nor the border node.
    always_comb begin
        logic [2*CFG_W-1:0] cells;
        logic [NODE_W-1:0]  cells_n;
        cells   = (2*CFG_W)'(h_eff) * (2*CFG_W)'(w_eff);
        cells_n = NODE_W'(cells);
        a_bad   = (a_reg >= cells_n) && (a_reg != BORDER);
        b_bad   = (b_reg >= cells_n) && (b_reg != BORDER);
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        k_next       = k_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cur_next     = cur_reg;
        ids_next     = ids_reg;
        size_next    = size_reg;
        sum_next     = sum_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg;
        mem_wdata    = '0;
        mem_raddr    = cur_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = {1'b1, NODE_W'(1)};
                if (clr_cnt_reg == BORDER) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next  = in_op;
                    a_next   = in_cell_a;
                    b_next   = in_cell_b;
                    row_next = in_row;
                    col_next = in_col;
                    k_next   = 2'd0;
                    res_next = '0;
                    state_next = (in_op == OP_JOIN) ? ST_JPREP : ST_CNODE;
                end
            end
            ST_JPREP: begin
                if (a_bad || b_bad) begin
                    state_next = ST_EMIT;
                end else begin
                    cur_next   = a_reg;
                    state_next = ST_RD;
                end
            end
            ST_CNODE: begin
                cur_next   = diag_node;
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (!rd_root) begin
                    // Follow the parent link; its read is issued in this cycle.
                    mem_raddr = rd_val;
                    cur_next  = rd_val;
                end else if (op_reg == OP_JOIN) begin
                    if (k_reg == 2'd0) begin
                        ids_next[0] = cur_reg;
                        size_next   = rd_val;
                        k_next      = 2'd1;
                        cur_next    = b_reg;
                        state_next  = ST_RD;
                    end else begin
                        ids_next[1] = cur_reg;
                        sum_next    = size_reg + rd_val;
                        state_next  = ST_JW1;
                    end
                end else begin
                    ids_next[k_reg] = cur_reg;
                    if (k_reg == 2'd3) begin
                        state_next = ST_CEVAL;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_CNODE;
                    end
                end
            end
            ST_JW1: begin
                if (ids_reg[0] == ids_reg[1]) begin
                    state_next = ST_EMIT;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = ids_reg[0];
                    mem_wdata  = {1'b1, sum_reg};
                    state_next = ST_JW2;
                end
            end
            ST_JW2: begin
                mem_we          = 1'b1;
                mem_waddr       = ids_reg[1];
                mem_wdata       = {1'b0, ids_reg[0]};
                res_next.merged = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_CEVAL: begin
                res_next.check_ok = cut_ok;
                state_next        = ST_EMIT;
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            k_reg       <= 2'd0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        cur_reg  <= cur_next;
        ids_reg  <= ids_next;
        size_reg <= size_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

### rtl/union_find_grid_cut_check.sv
// Per item: a join walks cell_a and cell_b to their roots, then writes the summed size to
// the root of cell_a and links the root of cell_b below it (no writes if both share a root,
// no walk if a node is invalid); a check walks from the four diagonal cells and tests the cut.
// Throughput: one item at a time; the next word can be taken in the cycle the result shows.
// Reset: synchronous, active low; afterwards a clearing pass over all MAX_SIDE*MAX_SIDE+1
// nodes (1025 by default) makes every node a root of size one before items flow.
`timescale 1ns / 1ps
`default_nettype none

module union_find_grid_cut_check #(
    parameter int MAX_SIDE = 32,
    localparam int NODE_W = $clog2(MAX_SIDE * MAX_SIDE + 1),
    localparam int SIDE_W = $clog2(MAX_SIDE),
    localparam int CFG_W  = $clog2(MAX_SIDE + 1),
    localparam int S_DATA_W = ((2 * NODE_W + 2 * SIDE_W + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // APB configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    // Input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // cell_a, cell_b, row, col, zero pad
    input  wire logic                s_axis_tuser,  // opcode
    // Result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [7:0]          m_axis_tdata   // check_ok, merged, zero pad
);
    import ufg_pkg::*;

    logic [CFG_W-1:0]  height_reg;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  h_eff;
    logic [CFG_W-1:0]  w_eff;
    logic              cfg_wr;
    logic              m_valid_reg, m_valid_next;
    ufg_res_t          m_res_reg, m_res_next;
    logic              out_free;
    logic              res_valid;
    ufg_res_t          res;
    logic [NODE_W-1:0] cell_a;
    logic [NODE_W-1:0] cell_b;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= CFG_W'(MAX_SIDE);
            width_reg  <= CFG_W'(MAX_SIDE);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                height_reg <= pwdata[CFG_W-1:0];
            end else begin
                width_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_WIDTH) begin
            prdata = 32'(width_reg);
        end else begin
            prdata = 32'(height_reg);
        end
    end

    // Out-of-range sizes: zero counts as one, anything above MAX_SIDE as MAX_SIDE.
    always_comb begin
        priority if (height_reg == '0) begin
            h_eff = CFG_W'(1);
        end else if (height_reg > CFG_W'(MAX_SIDE)) begin
            h_eff = CFG_W'(MAX_SIDE);
        end else begin
            h_eff = height_reg;
        end
        priority if (width_reg == '0) begin
            w_eff = CFG_W'(1);
        end else if (width_reg > CFG_W'(MAX_SIDE)) begin
            w_eff = CFG_W'(MAX_SIDE);
        end else begin
            w_eff = width_reg;
        end
    end

    assign cell_a = s_axis_tdata[NODE_W-1:0];
    assign cell_b = s_axis_tdata[2*NODE_W-1:NODE_W];
    assign row    = s_axis_tdata[2*NODE_W+SIDE_W-1:2*NODE_W];
    assign col    = s_axis_tdata[2*NODE_W+2*SIDE_W-1:2*NODE_W+SIDE_W];

    ufg_seq #(
        .MAX_SIDE(MAX_SIDE)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_cell_a(cell_a),
        .in_cell_b(cell_b),
        .in_row   (row),
        .in_col   (col),
        .h_eff    (h_eff),
        .w_eff    (w_eff),
        .out_free (out_free),
        .res_valid(res_valid),
        .res      (res)
    );

    // Output register: the result word waits here until the sink takes it.
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && out_free) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b000000, m_res_reg.merged, m_res_reg.check_ok};

endmodule

`default_nettype wire

### rtl/ufg_check.sv
// Port-level checker for union_find_grid_cut_check, attached by a bind statement.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module ufg_check (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed or dropped while stalled");

    // A join never reports a check pass, and a check never reports a merge.
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("result word carries both check_ok and merged");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[7:2] == 6'b000000)
        else $error("result pad bits are not zero");

    // Items are worked one at a time, so an accept always closes the input.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again right after an accept");

endmodule

bind union_find_grid_cut_check ufg_check u_ufg_check (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
